@@ design/fdsw_pkg.sv @@
// Package: types, codes and constants shared by the FAT directory sector walker.
`timescale 1ns / 1ps
`default_nettype none

package fdsw_pkg;

	localparam int unsigned SECTOR_BYTES_MAX_DEF = 4096;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_FAT   = 2'd2;

	localparam logic [2:0] REG_SPC        = 3'd0;
	localparam logic [2:0] REG_DATA_START = 3'd1;
	localparam logic [2:0] REG_FAT_START  = 3'd2;
	localparam logic [2:0] REG_ROOT_START = 3'd3;
	localparam logic [2:0] REG_ROOT_SECS  = 3'd4;
	localparam logic [2:0] REG_SIZE_LOG2  = 3'd5;
	localparam logic [2:0] REG_WIDE_FAT   = 3'd6;
	localparam logic [2:0] REG_SEC_LIMIT  = 3'd7;

	localparam logic [15:0] FAT12_LIMIT = 16'h0ff6;
	localparam logic [15:0] FAT16_LIMIT = 16'hfff6;
	localparam logic [15:0] FAT12_MASK  = 16'h0fff;

	localparam logic [3:0] SHIFT_MIN = 4'd9;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ROOT  = 2'd1,
		PH_CHAIN = 2'd2,
		PH_FAT   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ACT_READ = 2'd0,
		ACT_FAT  = 2'd1,
		ACT_DONE = 2'd2,
		ACT_FAIL = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		FAIL_NONE  = 3'd0,
		FAIL_READ  = 3'd1,
		FAIL_LIMIT = 3'd2,
		FAIL_BAD   = 3'd3,
		FAIL_UNEXP = 3'd4
	} fail_t;

	typedef struct packed {
		logic [7:0]  clus_len;
		logic [15:0] data_area_start;
		logic [15:0] fat_area_start;
		logic [15:0] root_area_start;
		logic [15:0] root_area_sectors;
		logic [3:0]  sector_size_log2;
		logic        wide_fat_mode;
		logic [7:0]  sector_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		clus_len:            8'd1,
		data_area_start:     16'd0,
		fat_area_start:      16'd1,
		root_area_start:     16'd0,
		root_area_sectors:   16'd14,
		sector_size_log2:    4'd9,
		wide_fat_mode:       1'b0,
		sector_limit:        8'd12
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] start_cluster;
		logic        read_failed;
		logic        last_entry_empty;
		logic [15:0] fat_word;
	} in_word_t;

	typedef struct packed {
		action_t     action;
		logic [15:0] sector;
		logic [11:0] fat_byte_offset;
		logic        fat_sector_same;
		logic [8:0]  sector_count;
		fail_t       fail_reason;
	} out_word_t;

endpackage

`default_nettype wire

@@ design/fdsw_cfg.sv @@
// Configuration register file of the FAT directory sector walker.
`timescale 1ns / 1ps
`default_nettype none

module fdsw_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_write,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [15:0]   cfg_data,
	output fdsw_pkg::cfg_t     cfg
);

	fdsw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fdsw_pkg::CFG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				fdsw_pkg::REG_SPC:        cfg_q.clus_len            <= cfg_data[7:0];
				fdsw_pkg::REG_DATA_START: cfg_q.data_area_start     <= cfg_data;
				fdsw_pkg::REG_FAT_START:  cfg_q.fat_area_start      <= cfg_data;
				fdsw_pkg::REG_ROOT_START: cfg_q.root_area_start     <= cfg_data;
				fdsw_pkg::REG_ROOT_SECS:  cfg_q.root_area_sectors   <= cfg_data;
				fdsw_pkg::REG_SIZE_LOG2:  cfg_q.sector_size_log2    <= cfg_data[3:0];
				fdsw_pkg::REG_WIDE_FAT:   cfg_q.wide_fat_mode       <= cfg_data[0];
				fdsw_pkg::REG_SEC_LIMIT:  cfg_q.sector_limit        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ design/fdsw_core.sv @@
// Walk state and per-word decision logic of the FAT directory sector walker.
`timescale 1ns / 1ps
`default_nettype none

module fdsw_core #(
	parameter int unsigned SECTOR_BYTES_MAX = fdsw_pkg::SECTOR_BYTES_MAX_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  fdsw_pkg::cfg_t          cfg,
	input  wire logic               step,
	input  fdsw_pkg::in_word_t      req,
	output fdsw_pkg::out_word_t     rsp,
	output fdsw_pkg::phase_t        phase
);

	// largest usable sector shift, clamped to 9..12
	localparam int LOG_FLOOR = $clog2(SECTOR_BYTES_MAX + 1) - 1;
	localparam int SHIFT_HI  = (LOG_FLOOR > 12) ? 12 : ((LOG_FLOOR < 9) ? 9 : LOG_FLOOR);
	localparam logic [3:0] SHIFT_HI_L = 4'(SHIFT_HI);

	fdsw_pkg::phase_t phase_q, phase_d;
	logic [15:0] cur_q, cur_d;
	logic [15:0] nsec_q, nsec_d;
	logic [7:0]  sic_q, sic_d;
	logic [8:0]  cnt_q, cnt_d;
	logic [15:0] lfs_q, lfs_d;
	logic        lfv_q, lfv_d;

	logic        is_start, rd_ok, fat_ok;
	logic [7:0]  csize;
	logic [3:0]  sh;
	logic [16:0] fat_byte, fat_idx, off_mask;
	logic [15:0] fsec;
	logic [11:0] foff;
	logic        fsame;
	logic [15:0] nxt, enter_c, c_m2, limit, chain_sec, nsec_inc;
	logic [23:0] prod;
	logic        enter_bad, enter_mark;
	logic [8:0]  cnt_inc;
	logic [7:0]  sic_inc;
	logic        over_limit, root_end, in_cluster;

	fdsw_pkg::action_t act;
	fdsw_pkg::fail_t   why;

	assign is_start = (req.kind == fdsw_pkg::KIND_START);
	assign rd_ok    = (req.kind == fdsw_pkg::KIND_DATA) &&
		(phase_q == fdsw_pkg::PH_ROOT || phase_q == fdsw_pkg::PH_CHAIN);
	assign fat_ok   = (req.kind == fdsw_pkg::KIND_FAT) && (phase_q == fdsw_pkg::PH_FAT);

	assign csize = (cfg.clus_len == 8'd0) ? 8'd1 : cfg.clus_len;

	always_comb begin
		sh = cfg.sector_size_log2;
		if (sh < fdsw_pkg::SHIFT_MIN) begin
			sh = fdsw_pkg::SHIFT_MIN;
		end
		if (sh > SHIFT_HI_L) begin
			sh = SHIFT_HI_L;
		end
	end

	// FAT entry location
	assign fat_byte = cfg.wide_fat_mode ? {cur_q, 1'b0}
		: ({1'b0, cur_q} + {2'b00, cur_q[15:1]});
	assign fat_idx  = fat_byte >> sh;
	assign off_mask = (17'd1 << sh) - 17'd1;
	assign fsec     = cfg.fat_area_start + fat_idx[15:0];
	assign foff     = 12'(fat_byte & off_mask);
	assign fsame    = lfv_q && (lfs_q == fsec);

	// next cluster decode
	assign nxt = cfg.wide_fat_mode ? req.fat_word
		: (cur_q[0] ? {4'b0000, req.fat_word[15:4]} : (req.fat_word & fdsw_pkg::FAT12_MASK));
	assign enter_c    = is_start ? req.start_cluster : nxt;
	assign limit      = cfg.wide_fat_mode ? fdsw_pkg::FAT16_LIMIT : fdsw_pkg::FAT12_LIMIT;
	assign enter_bad  = enter_c > limit;
	assign enter_mark = enter_c == (limit + 16'd1);
	assign c_m2       = enter_c - 16'd2;
	assign prod       = c_m2 * csize;
	assign chain_sec  = prod[15:0] + cfg.data_area_start;

	assign cnt_inc    = cnt_q + 9'd1;
	assign sic_inc    = sic_q + 8'd1;
	assign nsec_inc   = nsec_q + 16'd1;
	assign over_limit = cnt_inc > {1'b0, cfg.sector_limit};
	assign root_end   = {7'd0, cnt_inc} >= cfg.root_area_sectors;
	assign in_cluster = sic_inc < csize;

	// result decision
	always_comb begin
		act = fdsw_pkg::ACT_FAIL;
		why = fdsw_pkg::FAIL_UNEXP;
		rsp = '0;
		rsp.sector_count = cnt_q;
		if (is_start) begin
			rsp.sector_count = 9'd0;
			if (req.start_cluster == 16'd0) begin
				if (cfg.root_area_sectors == 16'd0) begin
					act = fdsw_pkg::ACT_DONE;
					why = fdsw_pkg::FAIL_NONE;
				end else begin
					act = fdsw_pkg::ACT_READ;
					why = fdsw_pkg::FAIL_NONE;
					rsp.sector = cfg.root_area_start;
				end
			end else if (req.start_cluster == 16'd1) begin
				why = fdsw_pkg::FAIL_BAD;
			end else if (enter_bad) begin
				act = enter_mark ? fdsw_pkg::ACT_FAIL : fdsw_pkg::ACT_DONE;
				why = enter_mark ? fdsw_pkg::FAIL_BAD : fdsw_pkg::FAIL_NONE;
			end else begin
				act = fdsw_pkg::ACT_READ;
				why = fdsw_pkg::FAIL_NONE;
				rsp.sector = chain_sec;
			end
		end else if (rd_ok) begin
			if (req.read_failed) begin
				why = fdsw_pkg::FAIL_READ;
			end else begin
				rsp.sector_count = cnt_inc;
				if (req.last_entry_empty) begin
					act = fdsw_pkg::ACT_DONE;
					why = fdsw_pkg::FAIL_NONE;
				end else if (over_limit) begin
					why = fdsw_pkg::FAIL_LIMIT;
				end else if (phase_q == fdsw_pkg::PH_ROOT) begin
					why = fdsw_pkg::FAIL_NONE;
					if (root_end) begin
						act = fdsw_pkg::ACT_DONE;
					end else begin
						act = fdsw_pkg::ACT_READ;
						rsp.sector = nsec_inc;
					end
				end else if (in_cluster) begin
					act = fdsw_pkg::ACT_READ;
					why = fdsw_pkg::FAIL_NONE;
					rsp.sector = nsec_inc;
				end else begin
					act = fdsw_pkg::ACT_FAT;
					why = fdsw_pkg::FAIL_NONE;
					rsp.sector = fsec;
					rsp.fat_byte_offset = foff;
					rsp.fat_sector_same = fsame;
				end
			end
		end else if (fat_ok) begin
			if (req.read_failed) begin
				why = fdsw_pkg::FAIL_READ;
			end else if (enter_bad) begin
				act = enter_mark ? fdsw_pkg::ACT_FAIL : fdsw_pkg::ACT_DONE;
				why = enter_mark ? fdsw_pkg::FAIL_BAD : fdsw_pkg::FAIL_NONE;
			end else begin
				act = fdsw_pkg::ACT_READ;
				why = fdsw_pkg::FAIL_NONE;
				rsp.sector = chain_sec;
			end
		end
		rsp.action = act;
		rsp.fail_reason = why;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		cur_d   = cur_q;
		nsec_d  = nsec_q;
		sic_d   = sic_q;
		cnt_d   = cnt_q;
		lfs_d   = lfs_q;
		lfv_d   = lfv_q;
		if (act == fdsw_pkg::ACT_DONE || act == fdsw_pkg::ACT_FAIL) begin
			phase_d = fdsw_pkg::PH_IDLE;
		end else if (act == fdsw_pkg::ACT_FAT) begin
			phase_d = fdsw_pkg::PH_FAT;
		end else if (is_start) begin
			phase_d = (req.start_cluster == 16'd0) ? fdsw_pkg::PH_ROOT : fdsw_pkg::PH_CHAIN;
		end else if (fat_ok) begin
			phase_d = fdsw_pkg::PH_CHAIN;
		end
		if (is_start) begin
			cnt_d = 9'd0;
			lfv_d = 1'b0;
			sic_d = 8'd0;
			if (act == fdsw_pkg::ACT_READ) begin
				if (req.start_cluster == 16'd0) begin
					cur_d  = 16'd0;
					nsec_d = cfg.root_area_start;
				end else begin
					cur_d  = enter_c;
					nsec_d = chain_sec;
				end
			end
		end else if (rd_ok) begin
			if (!req.read_failed) begin
				cnt_d = cnt_inc;
			end
			if (phase_q == fdsw_pkg::PH_CHAIN &&
				(act == fdsw_pkg::ACT_READ || act == fdsw_pkg::ACT_FAT)) begin
				sic_d = sic_inc;
			end
			if (act == fdsw_pkg::ACT_READ) begin
				nsec_d = nsec_inc;
			end
			if (act == fdsw_pkg::ACT_FAT) begin
				lfs_d = fsec;
				lfv_d = 1'b1;
			end
		end else if (fat_ok && act == fdsw_pkg::ACT_READ) begin
			cur_d  = enter_c;
			sic_d  = 8'd0;
			nsec_d = chain_sec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fdsw_pkg::PH_IDLE;
			cur_q   <= '0;
			nsec_q  <= '0;
			sic_q   <= '0;
			cnt_q   <= '0;
			lfs_q   <= '0;
			lfv_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			cur_q   <= cur_d;
			nsec_q  <= nsec_d;
			sic_q   <= sic_d;
			cnt_q   <= cnt_d;
			lfs_q   <= lfs_d;
			lfv_q   <= lfv_d;
		end
	end

	assign phase = phase_q;

endmodule

`default_nettype wire

@@ design/fat_directory_sector_walker.sv @@
// Top level of the FAT12/FAT16 directory sector walker.
`timescale 1ns / 1ps
`default_nettype none

// Walks one FAT12 or FAT16 directory one disk transaction per word: a start
// word (cluster 0 = root area) yields the first sector read, each finished
// sector read yields the next read, a FAT fetch request or the end of the walk,
// and each delivered FAT word yields the first read of the next cluster; a start
// or FAT word may also end the walk. Every request word gives exactly one
// response word. The block takes one word per clock cycle while responses are
// taken: the word sits in an input register, then the walk state is updated and
// the response computed, and the response is held in an output register until
// taken. The walk state loop through the core is the path that sets the rate;
// a stalled response holds the input register, which then holds req_ready low.
// Configuration writes take effect at the next edge and belong to idle times.
module fat_directory_sector_walker #(
	parameter int unsigned SECTOR_BYTES_MAX = fdsw_pkg::SECTOR_BYTES_MAX_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_write,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [15:0]     cfg_data,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  fdsw_pkg::in_word_t   req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output fdsw_pkg::out_word_t  rsp
);

	fdsw_pkg::cfg_t      cfg;
	fdsw_pkg::in_word_t  req_s1;
	fdsw_pkg::out_word_t rsp_s2, core_rsp;
	fdsw_pkg::phase_t    core_phase;
	logic                vld_s1, vld_s2;
	logic                advance, accept;

	fdsw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fdsw_core #(
		.SECTOR_BYTES_MAX (SECTOR_BYTES_MAX)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.req    (req_s1),
		.rsp    (core_rsp),
		.phase  (core_phase)
	);

	assign advance   = vld_s1 && (!vld_s2 || rsp_ready);
	assign req_ready = !vld_s1 || advance;
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				vld_s2 <= 1'b1;
			end else if (rsp_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= core_rsp;
		end
	end

	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

	// a finished or failed walk leaves the walker idle
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (core_rsp.action == fdsw_pkg::ACT_DONE ||
			core_rsp.action == fdsw_pkg::ACT_FAIL)
		|=> core_phase == fdsw_pkg::PH_IDLE)
	else $error("walker not idle after end of walk");

	// a FAT fetch request always waits for a FAT word
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && core_rsp.action == fdsw_pkg::ACT_FAT
		|=> core_phase == fdsw_pkg::PH_FAT)
	else $error("FAT request without FAT phase");

	// fail reason set exactly on failure
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.action == fdsw_pkg::ACT_FAIL) ==
			(rsp.fail_reason != fdsw_pkg::FAIL_NONE)))
	else $error("fail reason does not match action");

	// same-sector flag only on FAT requests
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.action != fdsw_pkg::ACT_FAT |-> !rsp.fat_sector_same)
	else $error("same-sector flag outside FAT request");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench: drives the FAT directory sector walker and checks every response word.
`timescale 1ns / 1ps

module testbench;
	import fdsw_pkg::*;

	localparam logic [1:0] KIND_BAD = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_SETTINGS = 10;
	localparam int WORDS_PER_SETTING = 175;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic req_valid, req_ready, rsp_valid, rsp_ready;
	in_word_t req;
	out_word_t rsp;

	fat_directory_sector_walker u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// walk model state and register copy
	cfg_t cfg;
	phase_t wk_phase;
	logic [15:0] wk_cluster, wk_sector, wk_fat_sec;
	logic [7:0] wk_sic;
	logic [8:0] wk_count;
	logic wk_fat_valid;

	out_word_t walk_rsp_q[$];
	in_word_t dir_in[$];
	bit dir_typed[$];
	out_word_t dir_rsp[$];
	logic [15:0] cfg_val [0:7];

	int n_words, n_checked, n_done, n_failed, n_fat, n_bad, n_shown, n_settings;
	int burst_left;
	bit hold_long;
	int stall_left, rx_tick, rx_mode;
	out_word_t got_rsp, want_rsp;

	function automatic out_word_t conclude(action_t a, logic [15:0] sec, logic [11:0] off,
			logic same, fail_t why);
		out_word_t r;
		r.action = a;
		r.sector = sec;
		r.fat_byte_offset = off;
		r.fat_sector_same = same;
		r.sector_count = wk_count;
		r.fail_reason = why;
		if (a == ACT_DONE || a == ACT_FAIL) begin
			wk_phase = PH_IDLE;
		end
		return r;
	endfunction

	function automatic out_word_t enter_cluster(logic [15:0] c);
		logic [15:0] lim;
		logic [31:0] spc, pos;
		lim = cfg.wide_fat_mode ? FAT16_LIMIT : FAT12_LIMIT;
		if (c > lim) begin
			if (c == lim + 16'd1) begin
				return conclude(ACT_FAIL, 16'd0, 12'd0, 1'b0, FAIL_BAD);
			end
			return conclude(ACT_DONE, 16'd0, 12'd0, 1'b0, FAIL_NONE);
		end
		spc = (cfg.clus_len == 8'd0) ? 32'd1 : {24'd0, cfg.clus_len};
		pos = ({16'd0, c} - 32'd2) * spc + {16'd0, cfg.data_area_start};
		wk_cluster = c;
		wk_sic = 8'd0;
		wk_sector = pos[15:0];
		wk_phase = PH_CHAIN;
		return conclude(ACT_READ, wk_sector, 12'd0, 1'b0, FAIL_NONE);
	endfunction

	function automatic out_word_t next_walk_rsp(in_word_t w);
		logic [3:0] sh;
		logic [16:0] fat_pos, fat_rel, fat_off;
		logic [15:0] fsec, nxt;
		logic [8:0] csize;
		logic same;
		if (w.kind == KIND_START) begin
			wk_count = 9'd0;
			wk_fat_valid = 1'b0;
			wk_sic = 8'd0;
			if (w.start_cluster == 16'd0) begin
				if (cfg.root_area_sectors == 16'd0) begin
					return conclude(ACT_DONE, 16'd0, 12'd0, 1'b0, FAIL_NONE);
				end
				wk_cluster = 16'd0;
				wk_sector = cfg.root_area_start;
				wk_phase = PH_ROOT;
				return conclude(ACT_READ, wk_sector, 12'd0, 1'b0, FAIL_NONE);
			end
			if (w.start_cluster == 16'd1) begin
				return conclude(ACT_FAIL, 16'd0, 12'd0, 1'b0, FAIL_BAD);
			end
			return enter_cluster(w.start_cluster);
		end
		if (w.kind == KIND_DATA && (wk_phase == PH_ROOT || wk_phase == PH_CHAIN)) begin
			if (w.read_failed) begin
				return conclude(ACT_FAIL, 16'd0, 12'd0, 1'b0, FAIL_READ);
			end
			wk_count = wk_count + 9'd1;
			if (w.last_entry_empty) begin
				return conclude(ACT_DONE, 16'd0, 12'd0, 1'b0, FAIL_NONE);
			end
			if (wk_count > {1'b0, cfg.sector_limit}) begin
				return conclude(ACT_FAIL, 16'd0, 12'd0, 1'b0, FAIL_LIMIT);
			end
			if (wk_phase == PH_ROOT) begin
				if ({7'd0, wk_count} >= cfg.root_area_sectors) begin
					return conclude(ACT_DONE, 16'd0, 12'd0, 1'b0, FAIL_NONE);
				end
				wk_sector = wk_sector + 16'd1;
				return conclude(ACT_READ, wk_sector, 12'd0, 1'b0, FAIL_NONE);
			end
			wk_sic = wk_sic + 8'd1;
			csize = (cfg.clus_len == 8'd0) ? 9'd1 : {1'b0, cfg.clus_len};
			if ({1'b0, wk_sic} < csize) begin
				wk_sector = wk_sector + 16'd1;
				return conclude(ACT_READ, wk_sector, 12'd0, 1'b0, FAIL_NONE);
			end
			sh = cfg.sector_size_log2;
			if (sh < SHIFT_MIN) sh = SHIFT_MIN;
			if (sh > 4'd12) sh = 4'd12;
			while (sh > SHIFT_MIN && (32'd1 << sh) > SECTOR_BYTES_MAX_DEF) sh = sh - 4'd1;
			if (cfg.wide_fat_mode) begin
				fat_pos = {wk_cluster, 1'b0};
			end else begin
				fat_pos = {1'b0, wk_cluster} + {2'b0, wk_cluster[15:1]};
			end
			fat_rel = fat_pos >> sh;
			fat_off = fat_pos & ((17'd1 << sh) - 17'd1);
			fsec = cfg.fat_area_start + fat_rel[15:0];
			same = wk_fat_valid && (wk_fat_sec == fsec);
			wk_fat_sec = fsec;
			wk_fat_valid = 1'b1;
			wk_phase = PH_FAT;
			return conclude(ACT_FAT, fsec, fat_off[11:0], same, FAIL_NONE);
		end
		if (w.kind == KIND_FAT && wk_phase == PH_FAT) begin
			if (w.read_failed) begin
				return conclude(ACT_FAIL, 16'd0, 12'd0, 1'b0, FAIL_READ);
			end
			if (cfg.wide_fat_mode) nxt = w.fat_word;
			else if (wk_cluster[0]) nxt = w.fat_word >> 4;
			else nxt = w.fat_word & FAT12_MASK;
			return enter_cluster(nxt);
		end
		return conclude(ACT_FAIL, 16'd0, 12'd0, 1'b0, FAIL_UNEXP);
	endfunction

	function automatic in_word_t noise_word();
		in_word_t w;
		w.kind = 2'($urandom_range(0, 3));
		w.start_cluster = 16'($urandom);
		w.read_failed = 1'($urandom_range(0, 1));
		w.last_entry_empty = 1'($urandom_range(0, 1));
		w.fat_word = 16'($urandom);
		return w;
	endfunction

	// mostly well-formed walks, some noise and early restarts
	function automatic in_word_t walk_word();
		in_word_t w;
		logic [15:0] lim, top, nxt;
		int r;
		w = noise_word();
		lim = cfg.wide_fat_mode ? FAT16_LIMIT : FAT12_LIMIT;
		top = cfg.wide_fat_mode ? 16'hffff : 16'h0fff;
		if ($urandom_range(0, 99) < 8) return w;
		if (wk_phase == PH_IDLE || $urandom_range(0, 99) < 3) begin
			w.kind = KIND_START;
			r = $urandom_range(0, 99);
			if (r < 20) w.start_cluster = 16'd0;
			else if (r < 25) w.start_cluster = 16'd1;
			else if (r < 70) w.start_cluster = 16'($urandom_range(2, 300));
			else if (r < 80) w.start_cluster = 16'($urandom);
			else if (r < 92) w.start_cluster = 16'(lim - 16'd2 + $urandom_range(0, 5));
			else w.start_cluster = lim + 16'd1;
		end else if (wk_phase == PH_FAT) begin
			w.kind = KIND_FAT;
			w.read_failed = ($urandom_range(0, 99) < 3);
			r = $urandom_range(0, 99);
			if (r >= 90) return w;
			if (r < 60) nxt = 16'($urandom_range(2, 400));
			else if (r < 68) nxt = 16'($urandom_range(2, lim));
			else if (r < 80) nxt = 16'($urandom_range(lim + 16'd2, top));
			else if (r < 85) nxt = lim + 16'd1;
			else nxt = 16'($urandom_range(0, 1));
			if (cfg.wide_fat_mode) w.fat_word = nxt;
			else if (wk_cluster[0]) w.fat_word = {nxt[11:0], w.fat_word[3:0]};
			else w.fat_word = {w.fat_word[15:12], nxt[11:0]};
		end else begin
			w.kind = KIND_DATA;
			w.read_failed = ($urandom_range(0, 99) < 3);
			w.last_entry_empty = ($urandom_range(0, 99) < 8);
		end
		return w;
	endfunction

	function automatic in_word_t mk_in(logic [1:0] kind, logic [15:0] start, logic failed,
			logic empty, logic [15:0] fat);
		in_word_t w;
		w.kind = kind;
		w.start_cluster = start;
		w.read_failed = failed;
		w.last_entry_empty = empty;
		w.fat_word = fat;
		return w;
	endfunction

	function automatic out_word_t mk_rsp(action_t a, logic [15:0] sec, logic [8:0] cnt,
			fail_t why);
		out_word_t r;
		r.action = a;
		r.sector = sec;
		r.fat_byte_offset = 12'd0;
		r.fat_sector_same = 1'b0;
		r.sector_count = cnt;
		r.fail_reason = why;
		return r;
	endfunction

	function automatic string show_rsp(out_word_t r);
		return $sformatf("action %0d sector %h offset %h same %0d count %0d reason %0d",
			r.action, r.sector, r.fat_byte_offset, r.fat_sector_same, r.sector_count,
			r.fail_reason);
	endfunction

	task automatic add_row(in_word_t w, bit typed, out_word_t r);
		dir_in.push_back(w);
		dir_typed.push_back(typed);
		dir_rsp.push_back(r);
	endtask

	task automatic send_word(in_word_t w, bit typed, out_word_t typed_rsp);
		out_word_t p;
		@(negedge clk);
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		p = next_walk_rsp(w);
		walk_rsp_q.push_back(typed ? typed_rsp : p);
		n_words++;
	endtask

	task automatic pace_sender();
		int r, gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			r = $urandom_range(0, 9);
			gap = (r < 3) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(10, 30);
			repeat (gap) begin
				@(negedge clk);
				req_valid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
		end
	endtask

	task automatic drain_rsp();
		@(negedge clk);
		req_valid <= 1'b0;
		while (walk_rsp_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_SPC:        cfg.clus_len = v[7:0];
			REG_DATA_START: cfg.data_area_start = v;
			REG_FAT_START:  cfg.fat_area_start = v;
			REG_ROOT_START: cfg.root_area_start = v;
			REG_ROOT_SECS:  cfg.root_area_sectors = v;
			REG_SIZE_LOG2:  cfg.sector_size_log2 = v[3:0];
			REG_WIDE_FAT:   cfg.wide_fat_mode = v[0];
			default:        cfg.sector_limit = v[7:0];
		endcase
	endtask

	task automatic program_setting(int p);
		logic [15:0] keep;
		int k, r;
		case (p)
			0: begin
				cfg_val[REG_SPC] = 16'd1;       cfg_val[REG_DATA_START] = 16'd0;
				cfg_val[REG_FAT_START] = 16'd0; cfg_val[REG_ROOT_START] = 16'd0;
				cfg_val[REG_ROOT_SECS] = 16'd1; cfg_val[REG_SIZE_LOG2] = 16'd9;
				cfg_val[REG_WIDE_FAT] = 16'd0;  cfg_val[REG_SEC_LIMIT] = 16'd1;
			end
			1: begin
				cfg_val[REG_SPC] = 16'd128;          cfg_val[REG_DATA_START] = 16'hffff;
				cfg_val[REG_FAT_START] = 16'hffff;   cfg_val[REG_ROOT_START] = 16'hffff;
				cfg_val[REG_ROOT_SECS] = 16'hffff;   cfg_val[REG_SIZE_LOG2] = 16'd12;
				cfg_val[REG_WIDE_FAT] = 16'd1;       cfg_val[REG_SEC_LIMIT] = 16'd255;
			end
			2: begin
				cfg_val[REG_SPC] = 16'd0;
				cfg_val[REG_DATA_START] = 16'($urandom);
				cfg_val[REG_FAT_START] = 16'($urandom);
				cfg_val[REG_ROOT_START] = 16'($urandom);
				cfg_val[REG_ROOT_SECS] = 16'd0;
				cfg_val[REG_SIZE_LOG2] = 16'($urandom_range(0, 1) ? $urandom_range(0, 8)
					: $urandom_range(13, 15));
				cfg_val[REG_WIDE_FAT] = 16'($urandom_range(0, 1));
				cfg_val[REG_SEC_LIMIT] = 16'd0;
			end
			default: begin
				r = $urandom_range(0, 9);
				cfg_val[REG_SPC] = 16'((r < 7) ? $urandom_range(1, 4)
					: (r < 9) ? $urandom_range(5, 16) : $urandom_range(0, 2) * 128);
				cfg_val[REG_DATA_START] = 16'($urandom);
				cfg_val[REG_FAT_START] = 16'($urandom);
				cfg_val[REG_ROOT_START] = 16'($urandom);
				r = $urandom_range(0, 9);
				cfg_val[REG_ROOT_SECS] = (r < 8) ? 16'($urandom_range(1, 20))
					: (r < 9) ? 16'd0 : 16'($urandom);
				cfg_val[REG_SIZE_LOG2] = 16'(($urandom_range(0, 4) != 0)
					? $urandom_range(9, 12) : $urandom_range(0, 15));
				cfg_val[REG_WIDE_FAT] = 16'($urandom_range(0, 1));
				r = $urandom_range(0, 9);
				cfg_val[REG_SEC_LIMIT] = (r < 7) ? 16'($urandom_range(1, 30))
					: (r < 9) ? 16'($urandom_range(31, 255)) : 16'd0;
			end
		endcase
		for (k = 0; k < 8; k++) begin
			case (k)
				REG_SPC, REG_SEC_LIMIT: keep = 16'h00ff;
				REG_SIZE_LOG2:          keep = 16'h000f;
				REG_WIDE_FAT:           keep = 16'h0001;
				default:                keep = 16'hffff;
			endcase
			if (p >= 2) cfg_val[k] = (16'($urandom) & ~keep) | (cfg_val[k] & keep);
			write_reg(3'(k), cfg_val[k]);
		end
		@(negedge clk);
		cfg_write <= 1'b0;
		n_settings++;
	endtask

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			got_rsp = rsp;
			n_checked++;
			if (got_rsp.action == ACT_DONE) n_done++;
			if (got_rsp.action == ACT_FAIL) n_failed++;
			if (got_rsp.action == ACT_FAT) n_fat++;
			if (walk_rsp_q.size() == 0) begin
				n_bad++;
				if (n_shown < 10) $display("%0t: response with none pending: %s", $time,
					show_rsp(got_rsp));
				n_shown++;
			end else begin
				want_rsp = walk_rsp_q.pop_front();
				if (got_rsp.action !== want_rsp.action || got_rsp.sector !== want_rsp.sector
						|| got_rsp.fat_byte_offset !== want_rsp.fat_byte_offset
						|| got_rsp.fat_sector_same !== want_rsp.fat_sector_same
						|| got_rsp.sector_count !== want_rsp.sector_count
						|| got_rsp.fail_reason !== want_rsp.fail_reason) begin
					n_bad++;
					if (n_shown < 10) begin
						$display("%0t: mismatch, expected %s", $time, show_rsp(want_rsp));
						$display("%0t:             got %s", $time, show_rsp(got_rsp));
					end
					n_shown++;
				end
			end
		end
	end

	// receiver: stall pattern is redrawn from four modes, plus one long hold-off
	initial begin
		rsp_ready = 1'b0;
		stall_left = 0;
		rx_tick = 0;
		rx_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				stall_left = 300;
			end
			if (rx_tick == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_tick = 128;
			end
			rx_tick--;
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(0, 1));
					2: rsp_ready <= ($urandom_range(0, 4) == 0);
					default: rsp_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d responses outstanding", CYCLE_LIMIT,
			walk_rsp_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int i, p, pause_at;
		out_word_t none;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_write = 1'b0;
		cfg_index = 3'd0;
		cfg_data = 16'd0;
		hold_long = 1'b0;
		burst_left = 0;
		n_words = 0; n_checked = 0; n_done = 0; n_failed = 0; n_fat = 0;
		n_bad = 0; n_shown = 0; n_settings = 0;
		cfg = CFG_RESET;
		wk_phase = PH_IDLE;
		wk_cluster = 16'd0; wk_sector = 16'd0; wk_sic = 8'd0; wk_count = 9'd0;
		wk_fat_sec = 16'd0; wk_fat_valid = 1'b0;
		none = mk_rsp(ACT_READ, 16'd0, 9'd0, FAIL_NONE);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed walk under the reset register values
		add_row(mk_in(KIND_DATA, 16'd0, 1'b0, 1'b0, 16'd0), 1,
			mk_rsp(ACT_FAIL, 16'd0, 9'd0, FAIL_UNEXP));
		add_row(mk_in(KIND_BAD, 16'hffff, 1'b1, 1'b1, 16'hffff), 1,
			mk_rsp(ACT_FAIL, 16'd0, 9'd0, FAIL_UNEXP));
		add_row(mk_in(KIND_FAT, 16'd0, 1'b0, 1'b0, 16'h1234), 1,
			mk_rsp(ACT_FAIL, 16'd0, 9'd0, FAIL_UNEXP));
		add_row(mk_in(KIND_START, 16'd1, 1'b0, 1'b0, 16'd0), 1,
			mk_rsp(ACT_FAIL, 16'd0, 9'd0, FAIL_BAD));
		add_row(mk_in(KIND_START, 16'h0ff7, 1'b0, 1'b0, 16'd0), 1,
			mk_rsp(ACT_FAIL, 16'd0, 9'd0, FAIL_BAD));
		add_row(mk_in(KIND_START, 16'hffff, 1'b0, 1'b0, 16'd0), 1,
			mk_rsp(ACT_DONE, 16'd0, 9'd0, FAIL_NONE));
		add_row(mk_in(KIND_START, 16'd0, 1'b1, 1'b1, 16'hffff), 1,
			mk_rsp(ACT_READ, 16'd0, 9'd0, FAIL_NONE));
		add_row(mk_in(KIND_DATA, 16'hffff, 1'b0, 1'b0, 16'hffff), 0, none);
		add_row(mk_in(KIND_DATA, 16'd0, 1'b0, 1'b1, 16'd0), 0, none);
		add_row(mk_in(KIND_START, 16'd0, 1'b0, 1'b0, 16'd0), 0, none);
		add_row(mk_in(KIND_DATA, 16'd0, 1'b1, 1'b0, 16'd0), 0, none);
		add_row(mk_in(KIND_START, 16'd2, 1'b0, 1'b0, 16'd0), 0, none);
		add_row(mk_in(KIND_DATA, 16'd0, 1'b0, 1'b0, 16'd0), 0, none);
		add_row(mk_in(KIND_FAT, 16'd0, 1'b0, 1'b0, 16'h0004), 0, none);
		add_row(mk_in(KIND_DATA, 16'd0, 1'b0, 1'b0, 16'd0), 0, none);
		add_row(mk_in(KIND_FAT, 16'd0, 1'b0, 1'b0, 16'hf000), 0, none);
		add_row(mk_in(KIND_DATA, 16'd0, 1'b0, 1'b0, 16'd0), 0, none);
		add_row(mk_in(KIND_FAT, 16'd0, 1'b1, 1'b0, 16'h0005), 0, none);
		add_row(mk_in(KIND_START, 16'd5, 1'b0, 1'b0, 16'd0), 0, none);
		add_row(mk_in(KIND_DATA, 16'd0, 1'b0, 1'b0, 16'd0), 0, none);
		add_row(mk_in(KIND_FAT, 16'd0, 1'b0, 1'b0, 16'h7ff0), 0, none);
		add_row(mk_in(KIND_DATA, 16'd0, 1'b0, 1'b0, 16'd0), 0, none);
		add_row(mk_in(KIND_FAT, 16'd0, 1'b0, 1'b0, 16'hff70), 0, none);
		add_row(mk_in(KIND_START, 16'd6, 1'b0, 1'b0, 16'd0), 0, none);
		add_row(mk_in(KIND_START, 16'd0, 1'b0, 1'b0, 16'd0), 0, none);
		for (i = 0; i < dir_in.size(); i++) begin
			send_word(dir_in[i], dir_typed[i], dir_rsp[i]);
			pace_sender();
		end
		drain_rsp();

		for (p = 0; p < N_SETTINGS; p++) begin
			program_setting(p);
			pause_at = $urandom_range(10, WORDS_PER_SETTING - 10);
			for (i = 0; i < WORDS_PER_SETTING; i++) begin
				if (p == 4 && i == 40) hold_long = 1'b1;
				if (i == pause_at) drain_rsp();
				send_word(walk_word(), 0, none);
				pace_sender();
			end
			drain_rsp();
		end

		repeat (8) @(posedge clk);
		$display("%0d request words over %0d register settings, %0d responses checked",
			n_words, n_settings, n_checked);
		$display("walks finished %0d, failed %0d, FAT fetches %0d, mismatches %0d",
			n_done, n_failed, n_fat, n_bad);
		if (n_bad == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/fdsw_pkg.sv
design/fdsw_cfg.sv
design/fdsw_core.sv
design/fat_directory_sector_walker.sv
tb/testbench.sv
